FILE: hw/rtl/ldt_pkg.sv
// Shared types and constants for the linear detrend block.
// No dependencies; imported by linear_detrend, ldt_fit and ldt_core.
`default_nettype none

package ldt_pkg;

  // Fraction bits of the fitted slope and intercept
  localparam int FRAC_BITS = 16;

  // Epoch length register
  localparam int              CFG_W     = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
  localparam int              MIN_LEN   = 2;

  // Depth of the command queue and of the result queue
  localparam int CMD_DEPTH = 4;
  localparam int RES_DEPTH = 4;

  // Command kinds, coded as the opcode field
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_kind_t;

  // Line fit sequencer states
  typedef enum logic [3:0] {
    FS_IDLE,
    FS_NUM_W,
    FS_NUM_V,
    FS_DEN_T,
    FS_DEN_S,
    FS_SLOPE_DIV,
    FS_SLOPE_RND,
    FS_INT_MUL,
    FS_INT_DIV,
    FS_INT_RND,
    FS_DONE
  } fit_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/linear_detrend.sv
// Reads: an accepted read word is registered in the read stage, then pushed into the result queue.
// Throughput: one load or read word per cycle while no fit runs and, for reads, while the
// result queue has room; the load that completes an epoch starts the line fit, which holds
// the back end until the serial multiplier and divider have finished.
// Reset clears queues, counts, sums and the fitted flag; the sample store is not cleared.
// Top level: command queue, back end (ldt_core) and result queue; uses ldt_pkg.
`default_nettype none

module linear_detrend #(
  parameter int MAX_EPOCH_LEN = 1024,
  parameter int SAMPLE_BITS   = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          opcode,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_value,
  output logic                               empty,
  input  wire logic                          pop,
  output logic signed [SAMPLE_BITS-1:0]      detrended_value,
  output logic                               last_sample,
  output logic                               not_ready,
  input  wire logic                          cfg_wen,
  input  wire logic [ldt_pkg::CFG_W-1:0]     cfg_wdata
);

  import ldt_pkg::*;

  localparam int SW = SAMPLE_BITS;
  localparam int NW = $clog2(MAX_EPOCH_LEN + 1);
  localparam int AW = $clog2(MAX_EPOCH_LEN);
  localparam int LW = SW + FRAC_BITS + 8;

  logic [CFG_W-1:0]     epoch_length;
  logic                 cmd_empty;
  logic                 cmd_pop;
  logic [SW:0]          cmd_dout;
  cmd_kind_t            cmd_kind;
  logic                 res_push;
  logic                 res_full;
  logic                 res_afull;
  logic signed [SW-1:0] res_value;
  logic                 res_last;
  logic                 res_nr;
  logic [SW+1:0]        res_dout;

  // Hold the epoch length register
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch_length <= CFG_RESET;
    end else if (cfg_wen) begin
      epoch_length <= cfg_wdata;
    end
  end

  // Front: queue each word with its opcode
  ldt_fifo #(
    .W    (SW + 1),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  ({opcode, sample_value}),
    .full (full),
    .afull(),
    .pop  (cmd_pop),
    .dout (cmd_dout),
    .empty(cmd_empty)
  );

  assign cmd_kind = cmd_kind_t'(cmd_dout[SW]);

  ldt_core #(
    .MAX(MAX_EPOCH_LEN),
    .NW (NW),
    .AW (AW),
    .SW (SW),
    .LW (LW)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .epoch_length(epoch_length),
    .cmd_valid   (!cmd_empty),
    .cmd_kind    (cmd_kind),
    .cmd_sample  ($signed(cmd_dout[SW-1:0])),
    .cmd_pop     (cmd_pop),
    .res_room    (!res_afull),
    .res_push    (res_push),
    .res_value   (res_value),
    .res_last    (res_last),
    .res_nr      (res_nr)
  );

  // Result queue
  ldt_fifo #(
    .W    (SW + 2),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  ({res_value, res_last, res_nr}),
    .full (res_full),
    .afull(res_afull),
    .pop  (pop),
    .dout (res_dout),
    .empty(empty)
  );

  assign detrended_value = $signed(res_dout[SW+1:2]);
  assign last_sample     = res_dout[1];
  assign not_ready       = res_dout[0];

  // The back end never overruns the result queue
  a_res_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue pushed while full");

  // The back end only takes commands that are queued
  a_cmd_no_underrun: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> !cmd_empty)
    else $error("command queue popped while empty");

  // A not-ready result carries a zero value and no last flag
  a_not_ready_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && not_ready) |-> (detrended_value == '0 && !last_sample))
    else $error("not-ready result with payload");

endmodule

`default_nettype wire

FILE: hw/rtl/ldt_fifo.sv
// Small synchronous word queue with full, empty and almost-full flags.
// Depends on nothing; used for the command queue and the result queue.
`default_nettype none

module ldt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  output logic              afull,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] level;
  logic          push_ok;
  logic          pop_ok;

  assign full    = (level == CW'(DEPTH));
  assign afull   = (level >= CW'(DEPTH - 1));
  assign empty   = (level == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rd_ptr];

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push_ok && !pop_ok) begin
        level <= level + CW'(1);
      end else if (pop_ok && !push_ok) begin
        level <= level - CW'(1);
      end
    end
  end

  // Store the pushed word
  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ldt_fit.sv
// Least-squares line fit: shift-add multiply-accumulate and restoring divider.
// Depends on ldt_pkg; instantiated once by ldt_core and started once per completed epoch.
`default_nettype none

module ldt_fit #(
  parameter int NW = 11,
  parameter int SW = 24,
  parameter int LW = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [NW-1:0]        n,
  input  wire logic [2*NW-1:0]      st,
  input  wire logic [3*NW-1:0]      stt,
  input  wire logic signed [SW+NW-1:0]   sum_v,
  input  wire logic signed [SW+2*NW-1:0] sum_w,
  output logic                      done,
  output logic signed [LW-1:0]      slope,
  output logic signed [LW-1:0]      intercept
);

  import ldt_pkg::*;

  localparam int SVW   = SW + NW;
  localparam int SWW   = SW + 2 * NW;
  localparam int MW    = 2 * NW;
  localparam int ACC_W = SW + FRAC_BITS + 4 * NW + 8;
  localparam int DVW   = 4 * NW;
  localparam int CNTW  = $clog2(ACC_W + 1);

  fit_state_t state;
  fit_state_t state_next;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] mcand;
  logic [MW-1:0]           mplier;
  logic signed [ACC_W-1:0] num;
  logic [ACC_W-1:0]        dq;
  logic [DVW-1:0]          rem;
  logic [DVW-1:0]          den;
  logic                    neg;
  logic [CNTW-1:0]         cnt;

  logic                    mac_run;
  logic                    mac_sub;
  logic                    mac_done;
  logic                    div_run;

  logic [ACC_W-1:0]        num_sh;
  logic [ACC_W-1:0]        num_abs;
  logic [ACC_W-1:0]        acc_abs;
  logic [DVW:0]            rem_sh;
  logic [DVW:0]            rem_sub;
  logic                    fits;
  logic                    rnd_up;
  logic [ACC_W-1:0]        q_rnd;
  logic [ACC_W-1:0]        q_sgn;
  logic signed [LW-1:0]    div_q;

  logic signed [ACC_W-1:0] sw_ext;
  logic signed [ACC_W-1:0] sv_ext;
  logic signed [ACC_W-1:0] sv_frac;
  logic signed [ACC_W-1:0] stt_ext;
  logic signed [ACC_W-1:0] st_ext;
  logic signed [ACC_W-1:0] q_ext;

  // Operand extension
  assign sw_ext  = {{(ACC_W - SWW){sum_w[SWW-1]}}, sum_w};
  assign sv_ext  = {{(ACC_W - SVW){sum_v[SVW-1]}}, sum_v};
  assign sv_frac = {{(ACC_W - SVW - FRAC_BITS){sum_v[SVW-1]}}, sum_v, {FRAC_BITS{1'b0}}};
  assign stt_ext = {{(ACC_W - 3 * NW){1'b0}}, stt};
  assign st_ext  = {{(ACC_W - 2 * NW){1'b0}}, st};
  assign q_ext   = {{(ACC_W - LW){div_q[LW-1]}}, div_q};

  // Dividend magnitudes
  assign num_sh  = {num[ACC_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
  assign num_abs = num_sh[ACC_W-1] ? (~num_sh + ACC_W'(1)) : num_sh;
  assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);

  // One restoring divide step
  assign rem_sh  = {rem, dq[ACC_W-1]};
  assign fits    = (rem_sh >= {1'b0, den});
  assign rem_sub = rem_sh - {1'b0, den};

  // Round half away from zero, then restore the sign
  assign rnd_up  = ({rem, 1'b0} >= {1'b0, den});
  assign q_rnd   = dq + ACC_W'(rnd_up);
  assign q_sgn   = neg ? (~q_rnd + ACC_W'(1)) : q_rnd;
  assign div_q   = q_sgn[LW-1:0];

  assign mac_done = (mplier == '0);

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and step controls
  always_comb begin
    state_next = state;
    mac_run    = 1'b0;
    mac_sub    = 1'b0;
    div_run    = 1'b0;
    done       = 1'b0;
    case (state)
      FS_IDLE: begin
        if (start) state_next = FS_NUM_W;
      end
      FS_NUM_W: begin
        mac_run = 1'b1;
        if (mac_done) state_next = FS_NUM_V;
      end
      FS_NUM_V: begin
        mac_run = 1'b1;
        mac_sub = 1'b1;
        if (mac_done) state_next = FS_DEN_T;
      end
      FS_DEN_T: begin
        mac_run = 1'b1;
        if (mac_done) state_next = FS_DEN_S;
      end
      FS_DEN_S: begin
        mac_run = 1'b1;
        mac_sub = 1'b1;
        if (mac_done) state_next = FS_SLOPE_DIV;
      end
      FS_SLOPE_DIV: begin
        div_run = 1'b1;
        if (cnt == '0) state_next = FS_SLOPE_RND;
      end
      FS_SLOPE_RND: begin
        state_next = FS_INT_MUL;
      end
      FS_INT_MUL: begin
        mac_run = 1'b1;
        mac_sub = 1'b1;
        if (mac_done) state_next = FS_INT_DIV;
      end
      FS_INT_DIV: begin
        div_run = 1'b1;
        if (cnt == '0) state_next = FS_INT_RND;
      end
      FS_INT_RND: begin
        state_next = FS_DONE;
      end
      FS_DONE: begin
        done       = 1'b1;
        state_next = FS_IDLE;
      end
      default: begin
        state_next = FS_IDLE;
      end
    endcase
  end

  // Datapath: multiply-accumulate, divide, and phase setup
  always_ff @(posedge clk) begin
    if (mac_run && !mac_done) begin
      if (mplier[0]) begin
        acc <= mac_sub ? (acc - mcand) : (acc + mcand);
      end
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
    end
    if (div_run && (cnt != '0)) begin
      rem <= fits ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
      dq  <= {dq[ACC_W-2:0], fits};
      cnt <= cnt - CNTW'(1);
    end
    case (state)
      FS_IDLE: begin
        if (start) begin
          acc    <= '0;
          mcand  <= sw_ext;
          mplier <= MW'(n);
        end
      end
      FS_NUM_W: begin
        if (mac_done) begin
          mcand  <= sv_ext;
          mplier <= st;
        end
      end
      FS_NUM_V: begin
        if (mac_done) begin
          num    <= acc;
          acc    <= '0;
          mcand  <= stt_ext;
          mplier <= MW'(n);
        end
      end
      FS_DEN_T: begin
        if (mac_done) begin
          mcand  <= st_ext;
          mplier <= st;
        end
      end
      FS_DEN_S: begin
        if (mac_done) begin
          neg <= num_sh[ACC_W-1];
          dq  <= num_abs;
          rem <= '0;
          den <= acc[DVW-1:0];
          cnt <= CNTW'(ACC_W);
        end
      end
      FS_SLOPE_RND: begin
        slope  <= div_q;
        acc    <= sv_frac;
        mcand  <= q_ext;
        mplier <= st;
      end
      FS_INT_MUL: begin
        if (mac_done) begin
          neg <= acc[ACC_W-1];
          dq  <= acc_abs;
          rem <= '0;
          den <= DVW'(n);
          cnt <= CNTW'(ACC_W);
        end
      end
      FS_INT_RND: begin
        intercept <= div_q;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/ldt_core.sv
// Back end: sample store, running sums, fit control and the registered read path.
// Depends on ldt_pkg and ldt_fit; fed by the command queue, feeds the result queue.
`default_nettype none

module ldt_core #(
  parameter int MAX = 1024,
  parameter int NW  = 11,
  parameter int AW  = 10,
  parameter int SW  = 24,
  parameter int LW  = 48
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic [ldt_pkg::CFG_W-1:0] epoch_length,
  input  wire logic                    cmd_valid,
  input  wire ldt_pkg::cmd_kind_t      cmd_kind,
  input  wire logic signed [SW-1:0]    cmd_sample,
  output logic                         cmd_pop,
  input  wire logic                    res_room,
  output logic                         res_push,
  output logic signed [SW-1:0]         res_value,
  output logic                         res_last,
  output logic                         res_nr
);

  import ldt_pkg::*;

  localparam int SVW    = SW + NW;
  localparam int SWW    = SW + 2 * NW;
  localparam int EW     = (NW > CFG_W) ? NW : CFG_W;
  localparam int LINE_W = LW - FRAC_BITS + 2;
  localparam int DW     = LINE_W + 1;
  localparam logic signed [DW-1:0] D_MAX = {{(DW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
  localparam logic signed [DW-1:0] D_MIN = {{(DW - SW + 1){1'b1}}, {(SW - 1){1'b0}}};
  localparam logic [LW:0] HALF = (LW + 1)'(1) << (FRAC_BITS - 1);

  // Epoch state
  logic [NW-1:0]           load_count;
  logic [AW-1:0]           read_index;
  logic signed [SVW-1:0]   sum_v;
  logic signed [SWW-1:0]   sum_w;
  logic [2*NW-1:0]         st;
  logic [3*NW-1:0]         stt;
  logic [2*NW-1:0]         tsq;
  logic                    epoch_fitted;
  logic                    fitting;
  logic                    fit_go;
  logic                    fit_done;
  logic signed [LW-1:0]    slope;
  logic signed [LW-1:0]    intercept;
  logic signed [LW-1:0]    fit_acc;
  logic signed [SW-1:0]    mem [MAX];

  // Read pipeline registers
  logic                    rd_v;
  logic                    rd_nr;
  logic                    rd_last;
  logic signed [LINE_W-1:0] rd_line;
  logic signed [SW-1:0]    mem_q;

  logic                    do_load;
  logic                    do_read;
  logic [EW-1:0]           len_ext;
  logic [NW-1:0]           n_eff;
  logic [NW-1:0]           t;
  logic [NW-1:0]           cnt_inc;
  logic signed [SVW-1:0]   sv0;
  logic signed [SWW-1:0]   sw0;
  logic [2*NW-1:0]         st0;
  logic [3*NW-1:0]         stt0;
  logic [2*NW-1:0]         tsq0;
  logic signed [SW+NW:0]   prod;
  logic                    rd_is_last;

  logic                    fa_neg;
  logic [LW-1:0]           fa_mag;
  logic [LW:0]             fa_sum;
  logic [LINE_W-1:0]       line_mag;
  logic signed [LINE_W-1:0] line_val;
  logic signed [DW-1:0]    d_full;
  logic signed [DW-1:0]    d_sat;

  // Clamp the epoch length
  always_comb begin
    len_ext = EW'(epoch_length);
    if (len_ext < EW'(MIN_LEN)) begin
      n_eff = NW'(MIN_LEN);
    end else if (len_ext > EW'(MAX)) begin
      n_eff = NW'(MAX);
    end else begin
      n_eff = len_ext[NW-1:0];
    end
  end

  // Classify the head command
  assign do_load = cmd_valid && (cmd_kind == CMD_LOAD) && !fitting;
  assign do_read = cmd_valid && (cmd_kind == CMD_READ) && !fitting && res_room;
  assign cmd_pop = do_load || do_read;

  // Load path: a load onto a fitted epoch starts over from zero
  assign t       = epoch_fitted ? '0 : load_count;
  assign sv0     = epoch_fitted ? '0 : sum_v;
  assign sw0     = epoch_fitted ? '0 : sum_w;
  assign st0     = epoch_fitted ? '0 : st;
  assign stt0    = epoch_fitted ? '0 : stt;
  assign tsq0    = epoch_fitted ? '0 : tsq;
  assign cnt_inc = t + NW'(1);
  assign prod    = $signed(cmd_sample) * $signed({1'b0, t});

  assign rd_is_last = ((NW'(read_index) + NW'(1)) >= load_count);

  // Round the line value half away from zero
  assign fa_neg   = fit_acc[LW-1];
  assign fa_mag   = fa_neg ? LW'(-fit_acc) : LW'(fit_acc);
  assign fa_sum   = {1'b0, fa_mag} + HALF;
  assign line_mag = {1'b0, fa_sum[LW:FRAC_BITS]};
  assign line_val = fa_neg ? -$signed(line_mag) : $signed(line_mag);

  // Sample minus line, saturated
  assign d_full = {{(DW - SW){mem_q[SW-1]}}, mem_q} - {rd_line[LINE_W-1], rd_line};
  always_comb begin
    if (d_full > D_MAX) begin
      d_sat = D_MAX;
    end else if (d_full < D_MIN) begin
      d_sat = D_MIN;
    end else begin
      d_sat = d_full;
    end
  end

  assign res_push  = rd_v;
  assign res_value = rd_nr ? '0 : d_sat[SW-1:0];
  assign res_last  = rd_last;
  assign res_nr    = rd_nr;

  // Control and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count   <= '0;
      read_index   <= '0;
      sum_v        <= '0;
      sum_w        <= '0;
      st           <= '0;
      stt          <= '0;
      tsq          <= '0;
      epoch_fitted <= 1'b0;
      fitting      <= 1'b0;
      fit_go       <= 1'b0;
      rd_v         <= 1'b0;
    end else begin
      fit_go <= 1'b0;
      rd_v   <= do_read;
      if (do_load) begin
        load_count   <= cnt_inc;
        read_index   <= '0;
        sum_v        <= sv0 + {{NW{cmd_sample[SW-1]}}, cmd_sample};
        sum_w        <= sw0 + {{(SWW - SW - NW - 1){prod[SW+NW]}}, prod};
        st           <= st0 + (2 * NW)'(t);
        stt          <= stt0 + (3 * NW)'(tsq0);
        tsq          <= tsq0 + (2 * NW)'({t, 1'b0}) + (2 * NW)'(1);
        epoch_fitted <= 1'b0;
        if (cnt_inc >= n_eff) begin
          fitting <= 1'b1;
          fit_go  <= 1'b1;
        end
      end
      if (fit_done) begin
        fitting      <= 1'b0;
        epoch_fitted <= 1'b1;
        read_index   <= '0;
      end
      if (do_read && epoch_fitted) begin
        if (rd_is_last) begin
          load_count   <= '0;
          read_index   <= '0;
          sum_v        <= '0;
          sum_w        <= '0;
          st           <= '0;
          stt          <= '0;
          tsq          <= '0;
          epoch_fitted <= 1'b0;
        end else begin
          read_index <= read_index + AW'(1);
        end
      end
    end
  end

  // Store samples; issue reads and step the line value
  always_ff @(posedge clk) begin
    if (do_load) begin
      mem[t[AW-1:0]] <= cmd_sample;
    end
    if (do_read) begin
      mem_q   <= mem[read_index];
      rd_nr   <= !epoch_fitted;
      rd_last <= epoch_fitted && rd_is_last;
      rd_line <= line_val;
    end
    if (fit_done) begin
      fit_acc <= intercept;
    end else if (do_read && epoch_fitted && !rd_is_last) begin
      fit_acc <= fit_acc + slope;
    end
  end

  ldt_fit #(
    .NW(NW),
    .SW(SW),
    .LW(LW)
  ) u_fit (
    .clk      (clk),
    .rst      (rst),
    .start    (fit_go),
    .n        (load_count),
    .st       (st),
    .stt      (stt),
    .sum_v    (sum_v),
    .sum_w    (sum_w),
    .done     (fit_done),
    .slope    (slope),
    .intercept(intercept)
  );

endmodule

`default_nettype wire
